// ===== rtl/fwsp_pkg.sv =====
`timescale 1ns / 1ps

package fwsp_pkg;

    localparam int WHEELS_DEF = 4;
    localparam int WHEEL_W    = 2;
    localparam int SPEED_W    = 16;
    localparam int GAIN_W     = 8;
    localparam int LEVEL_W    = 16;
    localparam int LIMIT_W    = 15;
    localparam int MASK_W     = 4;
    localparam int ERR_W      = 18;
    localparam int INTEG_W    = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int S_TDATA_W  = 40;
    localparam int M_TDATA_W  = 24;

    localparam logic [GAIN_W-1:0]  GAIN_P_RST    = 8'd1;
    localparam logic [GAIN_W-1:0]  GAIN_I_RST    = 8'd0;
    localparam logic [GAIN_W-1:0]  GAIN_D_RST    = 8'd0;
    localparam logic [LEVEL_W-1:0] OFFSET_RST    = 16'd200;
    localparam logic [LIMIT_W-1:0] LIMIT_RST     = 15'd100;
    localparam logic [LEVEL_W-1:0] DRIVE_MAX_RST = 16'd1000;
    localparam logic [MASK_W-1:0]  MAG_MASK_RST  = 4'd9;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GAIN_P    = 3'd0,
        REG_GAIN_I    = 3'd1,
        REG_GAIN_D    = 3'd2,
        REG_OFFSET    = 3'd3,
        REG_LIMIT     = 3'd4,
        REG_DRIVE_MAX = 3'd5,
        REG_MAG_MASK  = 3'd6
    } fwsp_reg_idx_t;

    typedef enum logic [1:0] {
        DIR_HOLD = 2'd0,
        DIR_FWD  = 2'd1,
        DIR_BACK = 2'd2
    } fwsp_dir_t;

    typedef struct packed {
        logic [GAIN_W-1:0]  gain_p;
        logic [GAIN_W-1:0]  gain_i;
        logic [GAIN_W-1:0]  gain_d;
        logic [LEVEL_W-1:0] drive_offset;
        logic [LIMIT_W-1:0] integral_limit;
        logic [LEVEL_W-1:0] drive_max;
        logic [MASK_W-1:0]  magnitude_mask;
    } fwsp_cfg_t;

    typedef struct packed {
        logic signed [INTEG_W-1:0] integ;
        logic signed [ERR_W-1:0]   last_err;
    } fwsp_state_t;

    typedef struct packed {
        fwsp_dir_t          direction;
        logic [LEVEL_W-1:0] level;
    } fwsp_drive_t;

endpackage

// ===== rtl/fwsp_calc.sv =====
`timescale 1ns / 1ps

module fwsp_calc
    import fwsp_pkg::*;
(
    input  fwsp_cfg_t                  cfg,
    input  logic                       mag,
    input  logic                       wheel_ok,
    input  logic signed [SPEED_W-1:0]  target,
    input  logic signed [SPEED_W-1:0]  measured,
    input  fwsp_state_t                state_cur,
    output fwsp_state_t                state_new,
    output fwsp_drive_t                drive
);

    localparam int SUM_W = 30;

    logic signed [ERR_W-1:0]   t_ext;
    logic signed [ERR_W-1:0]   m_ext;
    logic signed [ERR_W-1:0]   t_abs;
    logic signed [ERR_W-1:0]   err;
    logic signed [ERR_W:0]     isum;
    logic signed [ERR_W:0]     lim;
    logic signed [ERR_W:0]     iclamp;
    logic signed [ERR_W:0]     deriv;
    logic signed [26:0]        pprod;
    logic signed [26:0]        pterm;
    logic signed [24:0]        iprod;
    logic signed [27:0]        dprod;
    logic signed [SUM_W-1:0]   sum;
    logic signed [SUM_W-1:0]   max_ext;

    assign t_ext = {{(ERR_W-SPEED_W){target[SPEED_W-1]}}, target};
    assign m_ext = {{(ERR_W-SPEED_W){measured[SPEED_W-1]}}, measured};
    assign t_abs = target[SPEED_W-1] ? -t_ext : t_ext;
    assign err   = (mag ? t_abs : t_ext) - m_ext;

    // integral clamped to +-limit
    assign isum = {{(ERR_W+1-INTEG_W){state_cur.integ[INTEG_W-1]}}, state_cur.integ}
                + {err[ERR_W-1], err};
    assign lim  = {{(ERR_W+1-LIMIT_W){1'b0}}, cfg.integral_limit};

    always_comb begin
        priority if (isum > lim) begin
            iclamp = lim;
        end else if (isum < -lim) begin
            iclamp = -lim;
        end else begin
            iclamp = isum;
        end
    end

    assign deriv = {err[ERR_W-1], err}
                 - {state_cur.last_err[ERR_W-1], state_cur.last_err};

    assign pprod = $signed({1'b0, cfg.gain_p}) * err;
    assign pterm = (!mag && target[SPEED_W-1]) ? -pprod : pprod;
    assign iprod = $signed({1'b0, cfg.gain_i}) * $signed(iclamp[INTEG_W-1:0]);
    assign dprod = $signed({1'b0, cfg.gain_d}) * deriv;

    assign sum = SUM_W'(pterm) + SUM_W'(iprod) - SUM_W'(dprod)
               + $signed({{(SUM_W-LEVEL_W){1'b0}}, cfg.drive_offset});
    assign max_ext = $signed({{(SUM_W-LEVEL_W){1'b0}}, cfg.drive_max});

    assign state_new.integ    = iclamp[INTEG_W-1:0];
    assign state_new.last_err = err;

    always_comb begin
        drive.direction = DIR_HOLD;
        drive.level     = '0;
        if (wheel_ok && target != '0) begin
            drive.direction = target[SPEED_W-1] ? DIR_BACK : DIR_FWD;
            priority if (sum[SUM_W-1]) begin
                drive.level = '0;
            end else if (sum > max_ext) begin
                drive.level = cfg.drive_max;
            end else begin
                drive.level = sum[LEVEL_W-1:0];
            end
        end
    end

endmodule

// ===== rtl/four_wheel_speed_pid.sv =====
`timescale 1ns / 1ps
// Per-wheel PID speed controller, four wheels by default.
// Input stream: one beat per sample, carrying wheel number, signed target
// speed and signed measured encoder delta. Output stream: one beat per input
// beat, in order, carrying wheel number, direction code (0 hold, 1 forward,
// 2 backward) and a drive level saturated to 0..drive_max.
// Each wheel keeps a clamped integral and its previous error; both update on
// every sample of that wheel, including zero-target samples.
// Gains, offset, integral limit, drive max and magnitude mask are written
// through cfg_wr_en / cfg_index / cfg_wdata; the user must write them only
// while no beat is in flight; the block does not enforce this. A beat goes
// from the input register to the output register. Throughput: one beat per
// cycle while m_axis_tready is high; wheel state is read and written in the
// cycle a beat moves between them, so one wheel's samples may be adjacent.
// Reset (aresetn low, synchronous) clears both registers' valid flags, loads
// the default configuration and zeroes all wheel state.
// When m_axis_tready is low the output beat holds; one further beat is taken
// into the input register, then s_axis_tready drops.
module four_wheel_speed_pid
    import fwsp_pkg::*;
#(
    parameter int WHEELS = WHEELS_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,

    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // [1:0] wheel, [17:2] target_speed, [33:18] measured_speed, [39:34] zero
    input  logic [S_TDATA_W-1:0]   s_axis_tdata,

    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // [1:0] wheel_out, [3:2] direction, [19:4] drive_level, [23:20] zero
    output logic [M_TDATA_W-1:0]   m_axis_tdata,

    input  logic                   cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

    localparam int ST_DEPTH = (WHEELS < 4) ? WHEELS : 4;

    fwsp_cfg_t                  cfg_reg;
    fwsp_state_t                st_reg [ST_DEPTH];

    logic                       in_valid_reg;
    logic [WHEEL_W-1:0]         in_wheel_reg;
    logic signed [SPEED_W-1:0]  in_target_reg;
    logic signed [SPEED_W-1:0]  in_measured_reg;

    logic                       out_valid_reg;
    logic [WHEEL_W-1:0]         out_wheel_reg;
    fwsp_drive_t                out_drive_reg;

    logic                       s_accept;
    logic                       adv;
    logic                       wheel_ok;
    logic                       mag;
    fwsp_state_t                st_cur;
    fwsp_state_t                st_new;
    fwsp_drive_t                drive;

    assign adv           = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || adv;
    assign s_accept      = s_axis_tvalid && s_axis_tready;

    assign wheel_ok = int'(in_wheel_reg) < WHEELS;
    assign mag      = cfg_reg.magnitude_mask[in_wheel_reg];

    always_comb begin
        st_cur = '0;
        for (int e = 0; e < ST_DEPTH; e++) begin
            if (in_wheel_reg == WHEEL_W'(e)) begin
                st_cur = st_reg[e];
            end
        end
    end

    fwsp_calc u_calc (
        .cfg       (cfg_reg),
        .mag       (mag),
        .wheel_ok  (wheel_ok),
        .target    (in_target_reg),
        .measured  (in_measured_reg),
        .state_cur (st_cur),
        .state_new (st_new),
        .drive     (drive)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.gain_p         <= GAIN_P_RST;
            cfg_reg.gain_i         <= GAIN_I_RST;
            cfg_reg.gain_d         <= GAIN_D_RST;
            cfg_reg.drive_offset   <= OFFSET_RST;
            cfg_reg.integral_limit <= LIMIT_RST;
            cfg_reg.drive_max      <= DRIVE_MAX_RST;
            cfg_reg.magnitude_mask <= MAG_MASK_RST;
        end else if (cfg_wr_en) begin
            unique case (fwsp_reg_idx_t'(cfg_index))
                REG_GAIN_P:    cfg_reg.gain_p         <= cfg_wdata[GAIN_W-1:0];
                REG_GAIN_I:    cfg_reg.gain_i         <= cfg_wdata[GAIN_W-1:0];
                REG_GAIN_D:    cfg_reg.gain_d         <= cfg_wdata[GAIN_W-1:0];
                REG_OFFSET:    cfg_reg.drive_offset   <= cfg_wdata[LEVEL_W-1:0];
                REG_LIMIT:     cfg_reg.integral_limit <= cfg_wdata[LIMIT_W-1:0];
                REG_DRIVE_MAX: cfg_reg.drive_max      <= cfg_wdata[LEVEL_W-1:0];
                REG_MAG_MASK:  cfg_reg.magnitude_mask <= cfg_wdata[MASK_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int e = 0; e < ST_DEPTH; e++) begin
                st_reg[e] <= '0;
            end
        end else if (adv && wheel_ok) begin
            for (int e = 0; e < ST_DEPTH; e++) begin
                if (in_wheel_reg == WHEEL_W'(e)) begin
                    st_reg[e] <= st_new;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_accept) begin
            in_valid_reg <= 1'b1;
        end else if (adv) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_wheel_reg    <= s_axis_tdata[1:0];
            in_target_reg   <= s_axis_tdata[17:2];
            in_measured_reg <= s_axis_tdata[33:18];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (adv) begin
            out_valid_reg <= 1'b1;
        end else if (m_axis_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            out_wheel_reg <= in_wheel_reg;
            out_drive_reg <= drive;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {4'b0, out_drive_reg.level, out_drive_reg.direction,
                            out_wheel_reg};

    a_level_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> out_drive_reg.level <= cfg_reg.drive_max)
        else $error("drive level above drive_max");

    a_hold_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_drive_reg.direction == DIR_HOLD)
            |-> out_drive_reg.level == '0)
        else $error("nonzero level with hold direction");

    a_adv_fills_out: assert property (@(posedge aclk) disable iff (!aresetn)
        adv |=> out_valid_reg)
        else $error("advanced beat lost");

    a_in_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !adv) |=> (in_valid_reg && $stable(in_target_reg)
            && $stable(in_wheel_reg)))
        else $error("stalled input register changed");

endmodule
